// ----- sv/kwm_pkg.sv -----
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared sizes, codes and types of the K-way sorted merge core.
// ----------------------------------------------------------------------------
package kwm_pkg;

	localparam int NUM_LISTS  = 8;
	localparam int LIST_DEPTH = 64;

	localparam int VAL_W      = 32;
	localparam int ID_W       = 3;
	localparam int LIST_IDX_W = $clog2(NUM_LISTS);
	localparam int PTR_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
	localparam int STORE_DEPTH = NUM_LISTS * LIST_DEPTH;
	localparam int ADDR_W     = $clog2(STORE_DEPTH);
	localparam int TREE_N     = 2 ** LIST_IDX_W;
	localparam int LEVELS     = LIST_IDX_W;
	localparam int LVL_W      = $clog2(LEVELS + 1);

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 40;

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_PUSHED  = 2'd0,
		ST_DROPPED = 2'd1,
		ST_POPPED  = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(LIST_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [LIST_IDX_W-1:0] idx,
			input logic [PTR_W-1:0] ptr);
		return ADDR_W'(ADDR_W'(idx) * ADDR_W'(LIST_DEPTH)) + ADDR_W'(ptr);
	endfunction

endpackage

// ----- sv/k_way_sorted_merge_core.sv -----
// ----------------------------------------------------------------------------
// k_way_sorted_merge_core
// K bounded FIFOs in one list store; a pop returns the smallest head.
// Steps: a push goes from IDLE to DONE, which loads the output register; a pop
// runs the min tree in TREE, takes the winner in POP, passes REFILL when the
// popped list must refill its cached head from the list store, then DONE.
// One transaction is in work at a time; the input reopens once the result
// moves to the output register, which waits while the output stalls. Reset
// (arst_n, async) empties every list.
// ----------------------------------------------------------------------------
module k_way_sorted_merge_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [kwm_pkg::IN_DATA_W-1:0]   s_tdata,  // list_id[2:0], value[34:3], zero pad
	input  logic                            s_tuser,  // cmd[0]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [kwm_pkg::OUT_DATA_W-1:0]  m_tdata,  // out_value[31:0], source_list[34:32], pad
	output logic [1:0]                      m_tuser   // status[1:0]
);

	import kwm_pkg::*;

	typedef enum logic [2:0] {
		IDLE,
		TREE,
		POP,
		REFILL,
		DONE
	} state_t;

	state_t state_q;
	logic [LVL_W-1:0] lvl_q;

	// list bookkeeping
	logic [CNT_W-1:0] cnt_q   [NUM_LISTS];
	logic [PTR_W-1:0] rp_q    [NUM_LISTS];
	logic [PTR_W-1:0] wp_q    [NUM_LISTS];
	logic [VAL_W-1:0] heads_q [NUM_LISTS];

	// min-reduction registers, halved each TREE cycle
	logic signed [VAL_W-1:0] cand_val_q [TREE_N];
	logic [LIST_IDX_W-1:0]   cand_idx_q [TREE_N];
	logic                    cand_vld_q [TREE_N];

	status_t          res_status_q;
	logic [VAL_W-1:0] res_val_q;
	logic [ID_W-1:0]  res_src_q;

	logic             m_tvalid_q;
	status_t          m_status_q;
	logic [VAL_W-1:0] m_val_q;
	logic [ID_W-1:0]  m_src_q;

	logic                  in_fire;
	cmd_t                  in_cmd;
	logic [ID_W-1:0]       in_id;
	logic [VAL_W-1:0]      in_val;
	logic                  id_oor;
	logic [LIST_IDX_W-1:0] sel_idx;
	logic [CNT_W-1:0]      sel_cnt;
	logic [PTR_W-1:0]      sel_wp;
	logic [PTR_W-1:0]      sel_rp_next;
	logic                  push_drop;
	logic                  push_ok;
	logic                  pop_hit;
	logic                  pop_refill;
	logic [VAL_W-1:0]      ram_rdata;

	assign s_tready = (state_q == IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign in_cmd   = cmd_t'(s_tuser);
	assign in_id    = s_tdata[ID_W-1:0];
	assign in_val   = s_tdata[ID_W +: VAL_W];
	assign id_oor   = (32'(in_id) >= 32'(NUM_LISTS));

	// single shared index into the bookkeeping arrays
	assign sel_idx     = (state_q == IDLE) ? LIST_IDX_W'(in_id) : cand_idx_q[0];
	assign sel_cnt     = cnt_q[sel_idx];
	assign sel_wp      = wp_q[sel_idx];
	assign sel_rp_next = next_slot(rp_q[sel_idx]);

	assign push_drop  = id_oor || (sel_cnt == CNT_W'(LIST_DEPTH));
	assign push_ok    = in_fire && (in_cmd == CMD_PUSH) && !push_drop;
	assign pop_hit    = (state_q == POP) && cand_vld_q[0];
	assign pop_refill = pop_hit && (sel_cnt > CNT_W'(1));

	kwm_ram #(
		.DEPTH (STORE_DEPTH),
		.WIDTH (VAL_W)
	) u_store (
		.clk   (clk),
		.we    (push_ok),
		.waddr (slot_addr(sel_idx, sel_wp)),
		.wdata (in_val),
		.re    (pop_refill),
		.raddr (slot_addr(sel_idx, sel_rp_next)),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_LISTS; k++) begin
				cnt_q[k] <= '0;
				rp_q[k]  <= '0;
				wp_q[k]  <= '0;
			end
		end else if (push_ok) begin
			cnt_q[sel_idx] <= sel_cnt + CNT_W'(1);
			wp_q[sel_idx]  <= next_slot(sel_wp);
		end else if (pop_hit) begin
			cnt_q[sel_idx] <= sel_cnt - CNT_W'(1);
			rp_q[sel_idx]  <= sel_rp_next;
		end
	end

	// cached heads: loaded on a push into an empty list or by refill
	always_ff @(posedge clk) begin
		if (push_ok && (sel_cnt == '0)) begin
			heads_q[sel_idx] <= in_val;
		end else if (state_q == REFILL) begin
			heads_q[sel_idx] <= ram_rdata;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && (in_cmd == CMD_POP)) begin
			for (int k = 0; k < TREE_N; k++) begin
				cand_idx_q[k] <= LIST_IDX_W'(k);
				if (k < NUM_LISTS) begin
					cand_val_q[k] <= heads_q[k];
					cand_vld_q[k] <= (cnt_q[k] != '0);
				end else begin
					cand_val_q[k] <= '0;
					cand_vld_q[k] <= 1'b0;
				end
			end
		end else if (state_q == TREE) begin
			// lower index wins ties
			for (int i = 0; i < TREE_N / 2; i++) begin
				if (!cand_vld_q[2*i+1] || (cand_vld_q[2*i] &&
						!(cand_val_q[2*i+1] < cand_val_q[2*i]))) begin
					cand_val_q[i] <= cand_val_q[2*i];
					cand_idx_q[i] <= cand_idx_q[2*i];
					cand_vld_q[i] <= cand_vld_q[2*i];
				end else begin
					cand_val_q[i] <= cand_val_q[2*i+1];
					cand_idx_q[i] <= cand_idx_q[2*i+1];
					cand_vld_q[i] <= cand_vld_q[2*i+1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			lvl_q        <= '0;
			res_status_q <= ST_PUSHED;
			res_val_q    <= '0;
			res_src_q    <= '0;
			m_tvalid_q   <= 1'b0;
			m_status_q   <= ST_PUSHED;
			m_val_q      <= '0;
			m_src_q      <= '0;
		end else begin
			// DONE reloads the output register itself
			if (m_tvalid_q && m_tready && (state_q != DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (in_fire) begin
						res_val_q <= '0;
						res_src_q <= '0;
						lvl_q     <= '0;
						if (in_cmd == CMD_POP) begin
							state_q <= TREE;
						end else begin
							res_status_q <= push_drop ? ST_DROPPED : ST_PUSHED;
							state_q      <= DONE;
						end
					end
				end
				TREE: begin
					lvl_q <= lvl_q + LVL_W'(1);
					if (lvl_q == LVL_W'(LEVELS - 1)) begin
						state_q <= POP;
					end
				end
				POP: begin
					if (cand_vld_q[0]) begin
						res_status_q <= ST_POPPED;
						res_val_q    <= cand_val_q[0];
						res_src_q    <= ID_W'(cand_idx_q[0]);
						state_q      <= pop_refill ? REFILL : DONE;
					end else begin
						res_status_q <= ST_EMPTY;
						state_q      <= DONE;
					end
				end
				REFILL: begin
					state_q <= DONE;
				end
				DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_status_q <= res_status_q;
						m_val_q    <= res_val_q;
						m_src_q    <= res_src_q;
						state_q    <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {(OUT_DATA_W - VAL_W - ID_W)'(0), m_src_q, m_val_q};

	// a refill read is only issued from the pop step
	a_refill_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == REFILL |-> $past(state_q) == POP)
		else $error("refill without pop");

	// the tree winner must name a list that holds entries
	a_winner_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == POP && cand_vld_q[0]) |-> cnt_q[cand_idx_q[0]] != '0)
		else $error("pop winner is an empty list");

	// a popped result always comes from a list index in range
	a_src_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_status_q == ST_POPPED) |-> 32'(m_src_q) < 32'(NUM_LISTS))
		else $error("popped source out of range");

	// the store is written only while accepting a push
	a_write_on_push: assert property (@(posedge clk) disable iff (!arst_n)
		push_ok |=> state_q == DONE && res_status_q == ST_PUSHED)
		else $error("store write without a push result");

endmodule

// ----- sv/kwm_ram.sv -----
// ----------------------------------------------------------------------------
// kwm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module kwm_ram #(
	parameter int DEPTH  = 512,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
